@@ sv/sms_pkg.sv @@
// Shared types, constants and byte-compare functions for the substring match stream.
// No dependencies; imported by sms_front, sms_back and the top module.
package sms_pkg;

    // Fixed field widths
    localparam int TEXT_W         = 8;
    localparam int LEN_W          = 5;
    localparam int VIEW_W         = 24;
    localparam int MATCH_START_W  = 24;
    localparam int MATCH_NUMBER_W = 20;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 6;
    localparam int QUERY_BITS     = 128;

    // Parameter defaults
    localparam int MAX_QUERY_DEF     = 16;
    localparam int POSITION_BITS_DEF = 24;

    // Register map, one 64-bit register every 8 bytes
    typedef enum logic [2:0] {
        REG_QUERY_LOW  = 3'd0,
        REG_QUERY_HIGH = 3'd1,
        REG_QUERY_LEN  = 3'd2,
        REG_CASE_SENS  = 3'd3,
        REG_SMART_CASE = 3'd4,
        REG_VIEW_OFS   = 3'd5
    } sms_reg_t;

    // Control flags of one queued item
    typedef struct packed {
        logic cand;   // window matches, holdoff still to be applied
        logic last;   // final byte of the text
    } sms_item_t;

    // ASCII A-Z to a-z, everything else unchanged
    function automatic logic [TEXT_W-1:0] fold_byte(input logic [TEXT_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'h20;
        return c;
    endfunction

    // One query byte against one text byte under the current mode
    function automatic logic byte_match(input logic [TEXT_W-1:0] q,
                                        input logic [TEXT_W-1:0] t,
                                        input logic              case_sens,
                                        input logic              smart);
        if (!case_sens)
            return fold_byte(q) == fold_byte(t);
        if (smart && q >= 8'h61 && q <= 8'h7A)
            return (t == q) || (t == (q - 8'h20));
        return q == t;
    endfunction

endpackage

@@ sv/sms_fifo.sv @@
// Two-entry queue between the compare front end and the match back end.
// Depends on nothing; the payload width is a parameter.
module sms_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_data;
    end

endmodule

@@ sv/sms_front.sv @@
// Front end: takes text bytes, keeps the recent-byte window and byte position,
// compares the window with the query. Depends on sms_pkg.
module sms_front
    import sms_pkg::*;
#(
    parameter int MAX_QUERY     = MAX_QUERY_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [TEXT_W-1:0]        in_byte,
    input  logic                     in_last,
    input  logic [QUERY_BITS-1:0]    query,
    input  logic [LEN_W-1:0]         len_eff,
    input  logic                     case_sens,
    input  logic                     smart,
    output logic                     push_valid,
    input  logic                     push_ready,
    output sms_item_t                push_item,
    output logic [POSITION_BITS-1:0] push_rel_start
);

    localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

    logic [TEXT_W-1:0]        win_reg  [MAX_QUERY];
    logic [TEXT_W-1:0]        win_next [MAX_QUERY];
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]         len_m1;
    logic [LEN_W-1:0]         idx_full;
    logic                     all_ok;
    logic                     accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign len_m1     = len_eff - LEN_W'(1);

    // Shifted window and parallel compare against every query byte below len_eff
    always_comb
    begin
        idx_full    = '0;
        all_ok      = 1'b1;
        win_next[0] = in_byte;
        for (int k = 1; k < MAX_QUERY; k++)
            win_next[k] = win_reg[k-1];
        for (int j = 0; j < MAX_QUERY; j++)
        begin
            idx_full = len_m1 - LEN_W'(j);
            if (LEN_W'(j) < len_eff)
            begin
                if (!byte_match(query[8*j +: 8], win_next[idx_full[IDX_W-1:0]],
                                case_sens, smart))
                    all_ok = 1'b0;
            end
        end
    end

    // Item flags and offset of the first byte of a candidate match
    always_comb
    begin
        push_item.cand = (len_eff != '0) && (pos_reg >= POSITION_BITS'(len_m1)) && all_ok;
        push_item.last = in_last;
        push_rel_start = pos_reg - POSITION_BITS'(len_m1);
    end

    // Saturating position, cleared after the final byte
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (in_last)
                pos_next = '0;
            else if (pos_reg != {POSITION_BITS{1'b1}})
                pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // Window bytes are only read once the position shows they were written
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

@@ sv/sms_back.sv @@
// Back end: applies the overlap holdoff, keeps the match count and drives the
// result register. Depends on sms_pkg.
module sms_back
    import sms_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  sms_item_t                 item,
    input  logic [POSITION_BITS-1:0]  item_rel_start,
    input  logic [LEN_W-1:0]          len_eff,
    input  logic                      smart,
    input  logic [VIEW_W-1:0]         view_offset,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [MATCH_START_W-1:0]  out_start,
    output logic [MATCH_NUMBER_W-1:0] out_number
);

    localparam int SUM_W = ((POSITION_BITS > VIEW_W) ? POSITION_BITS : VIEW_W) + 1;
    localparam logic [SUM_W-1:0] POS_MAX = SUM_W'({POSITION_BITS{1'b1}});

    logic                      out_valid_reg, out_valid_next;
    logic [MATCH_START_W-1:0]  start_reg, start_next;
    logic [MATCH_NUMBER_W-1:0] number_reg;
    logic [LEN_W-1:0]          holdoff_reg, holdoff_next;
    logic [MATCH_NUMBER_W-1:0] total_reg, total_next, total_inc;
    logic [SUM_W-1:0]          start_sum;
    logic [POSITION_BITS-1:0]  start_sat;
    logic                      pop, hit;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign out_start  = start_reg;
    assign out_number = number_reg;

    // Holdoff gate and saturating start position
    always_comb
    begin
        hit       = item.cand && ((holdoff_reg == '0) || smart);
        start_sum = SUM_W'(view_offset) + SUM_W'(item_rel_start);
        start_sat = (start_sum > POS_MAX) ? {POSITION_BITS{1'b1}}
                                          : start_sum[POSITION_BITS-1:0];
        start_next = MATCH_START_W'(start_sat);
        total_inc  = (total_reg != {MATCH_NUMBER_W{1'b1}}) ? total_reg + MATCH_NUMBER_W'(1)
                                                            : total_reg;
    end

    // Per-text state: holdoff counts down each byte, reloads on a non-overlapping hit when smart case is off
    always_comb
    begin
        holdoff_next = holdoff_reg;
        total_next   = total_reg;
        if (pop)
        begin
            holdoff_next = (holdoff_reg != '0) ? holdoff_reg - LEN_W'(1) : holdoff_reg;
            if (hit)
            begin
                total_next = total_inc;
                if (!smart)
                    holdoff_next = len_eff - LEN_W'(1);
            end
            if (item.last)
            begin
                holdoff_next = '0;
                total_next   = '0;
            end
        end
    end

    // Result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = hit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            holdoff_reg   <= '0;
            total_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            holdoff_reg   <= holdoff_next;
            total_reg     <= total_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop && hit)
        begin
            start_reg  <= start_next;
            number_reg <= total_inc;
        end
    end

endmodule

@@ sv/substring_match_stream_top.sv @@
// Substring match stream: text bytes in on a stream slave, matches out on a
// stream master, query and mode set over an APB-style port.
// Instantiates sms_front, sms_fifo and sms_back; depends on sms_pkg.
//
// s_axis carries one text byte per transfer; tlast marks the final byte of a
// text, after which position, holdoff and match count start afresh.
// m_axis carries one transfer per match: start position (view offset added,
// saturating) and the running match number within the text.
// Registers (64-bit, byte address 8*i): query bytes 0-7, query bytes 8-15,
// query length, case sensitive, smart case, view offset. Write them only
// while no text is in flight.
// One byte is taken every cycle while the queue has room. The window compare
// is done as the byte is taken; the item then waits in the two-entry queue and
// the back end applies holdoff and count as it leaves, registering m_axis_tvalid.
// When the receiver stalls the result register holds, the two-entry queue
// fills and s_axis_tready drops; it rises again in the cycle after the stall ends.
// rst_n clears the registers to their defaults (query length 1, case
// sensitive) and empties the queue and result register.
module substring_match_stream_top
    import sms_pkg::*;
#(
    parameter int MAX_QUERY     = MAX_QUERY_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB-style configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // Text in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,   // end_of_text
    // Matches out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata    // [23:0] match_start, [43:24] match_number
);

    localparam int ITEM_W  = $bits(sms_item_t);
    localparam int QITEM_W = ITEM_W + POSITION_BITS;

    logic [CFG_DATA_W-1:0]     query_low_reg;
    logic [CFG_DATA_W-1:0]     query_high_reg;
    logic [LEN_W-1:0]          query_len_reg;
    logic                      case_sens_reg;
    logic                      smart_case_reg;
    logic [VIEW_W-1:0]         view_ofs_reg;
    logic                      cfg_write;
    sms_reg_t                  cfg_sel;
    logic [LEN_W-1:0]          len_eff;
    logic                      smart;

    logic                      push_valid, push_ready;
    sms_item_t                 push_item;
    logic [POSITION_BITS-1:0]  push_rel_start;
    logic                      pop_valid, pop_ready;
    logic [QITEM_W-1:0]        pop_data;
    sms_item_t                 pop_item;
    logic [POSITION_BITS-1:0]  pop_rel_start;
    logic [MATCH_START_W-1:0]  match_start;
    logic [MATCH_NUMBER_W-1:0] match_number;

    assign pready    = 1'b1;
    assign cfg_sel   = sms_reg_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= LEN_W'(1);
            case_sens_reg  <= 1'b1;
            smart_case_reg <= 1'b0;
            view_ofs_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_QUERY_LOW:  query_low_reg  <= pwdata;
                REG_QUERY_HIGH: query_high_reg <= pwdata;
                REG_QUERY_LEN:  query_len_reg  <= pwdata[LEN_W-1:0];
                REG_CASE_SENS:  case_sens_reg  <= pwdata[0];
                REG_SMART_CASE: smart_case_reg <= pwdata[0];
                REG_VIEW_OFS:   view_ofs_reg   <= pwdata[VIEW_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (cfg_sel)
            REG_QUERY_LOW:  prdata = query_low_reg;
            REG_QUERY_HIGH: prdata = query_high_reg;
            REG_QUERY_LEN:  prdata = CFG_DATA_W'(query_len_reg);
            REG_CASE_SENS:  prdata = CFG_DATA_W'(case_sens_reg);
            REG_SMART_CASE: prdata = CFG_DATA_W'(smart_case_reg);
            REG_VIEW_OFS:   prdata = CFG_DATA_W'(view_ofs_reg);
            default:        prdata = '0;
        endcase
    end

    // Mode decode and query length clamp
    assign smart   = case_sens_reg && smart_case_reg;
    assign len_eff = (query_len_reg > LEN_W'(MAX_QUERY)) ? LEN_W'(MAX_QUERY) : query_len_reg;

    sms_front #(
        .MAX_QUERY     (MAX_QUERY),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_byte        (s_axis_tdata),
        .in_last        (s_axis_tlast),
        .query          ({query_high_reg, query_low_reg}),
        .len_eff        (len_eff),
        .case_sens      (case_sens_reg),
        .smart          (smart),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item),
        .push_rel_start (push_rel_start)
    );

    sms_fifo #(
        .WIDTH (QITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_item, push_rel_start}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    assign pop_item      = sms_item_t'(pop_data[QITEM_W-1:POSITION_BITS]);
    assign pop_rel_start = pop_data[POSITION_BITS-1:0];

    sms_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (pop_valid),
        .item_ready     (pop_ready),
        .item           (pop_item),
        .item_rel_start (pop_rel_start),
        .len_eff        (len_eff),
        .smart          (smart),
        .view_offset    (view_ofs_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_start      (match_start),
        .out_number     (match_number)
    );

    assign m_axis_tdata = {4'b0000, match_number, match_start};

endmodule
